// ===== rtl/nmea_sentence_checksum_checker_defines.svh =====
// Assertion macros for the checksum checker's assertion module.
// Depends on nothing; the using module must provide i_clk and i_rst_n.
`ifndef NMEA_SENTENCE_CHECKSUM_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECKER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define NMEA_CHK_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define NMEA_CHK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nmea_chk_pkg.sv =====
// Shared types, constants and helpers for the NMEA sentence checksum checker.
// No dependencies.
package nmea_chk_pkg;

    localparam int MAX_SENTENCE_LEN_DEF = 256;
    localparam int DIGIT_COUNT          = 2;

    localparam logic [7:0] DOLLAR_CHAR = 8'h24;
    localparam logic [7:0] STAR_CHAR   = 8'h2A;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        t_status    status;
        logic [7:0] computed;
        logic [7:0] received;
        logic [7:0] plen;
    } t_result;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            h.val = 4'(c - CHAR_0);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            h.val = 4'(c - CHAR_UA + 8'd10);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            h.val = 4'(c - CHAR_LA + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== rtl/nmea_chk_in_if.sv =====
// Input byte channel: valid/ready plus one sentence byte and its end flag.
// No dependencies.
interface nmea_chk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/nmea_chk_out_if.sv =====
// Result channel: valid/ready plus status, both checksums and payload length.
// Depends on nmea_chk_pkg.
interface nmea_chk_out_if
    import nmea_chk_pkg::*;
;
    logic       valid;
    logic       ready;
    t_status    status;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [7:0] payload_length;

    modport source (output valid, output status, output computed_checksum,
                    output received_checksum, output payload_length, input ready);
    modport sink   (input valid, input status, input computed_checksum,
                    input received_checksum, input payload_length, output ready);
endinterface

// ===== rtl/nmea_chk_cfg_if.sv =====
// Configuration write channel: valid/ready plus the skip_check register value.
// No dependencies.
interface nmea_chk_cfg_if;
    logic valid;
    logic ready;
    logic skip_check;

    modport source (output valid, output skip_check, input ready);
    modport sink   (input valid, input skip_check, output ready);
endinterface

// ===== rtl/nmea_chk_eval.sv =====
// Final-byte evaluation: checksum form check, hex decode, status and length.
// Depends on nmea_chk_pkg.
module nmea_chk_eval
    import nmea_chk_pkg::*;
#(
    parameter  int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF,
    localparam int CntW             = $clog2(MAX_SENTENCE_LEN + 2)
) (
    input  logic [CntW-1:0]  i_len,
    input  logic             i_dollar,
    input  logic [2:0][7:0]  i_tail,
    input  logic [7:0]       i_xor,
    input  logic             i_skip,
    output t_result          o_res
);

    localparam int PlW = (CntW > 8) ? CntW : 8;

    logic [CntW-1:0] body;
    t_hex            hi;
    t_hex            lo;
    logic            formed;
    logic [7:0]      received;
    t_status         status;
    logic [PlW-1:0]  plen_full;

    always_comb begin
        body     = i_len - CntW'(i_dollar);
        hi       = hex_value(i_tail[1]);
        lo       = hex_value(i_tail[0]);
        formed   = (body >= CntW'(DIGIT_COUNT + 1)) && (i_tail[2] == STAR_CHAR)
                   && hi.ok && lo.ok;
        received = formed ? {hi.val, lo.val} : 8'd0;

        if (i_len > CntW'(MAX_SENTENCE_LEN)) begin
            status = ST_RANGE;
        end else if (i_skip) begin
            status = (i_len >= CntW'(DIGIT_COUNT)) ? ST_VALID : ST_MALFORMED;
        end else if (!formed) begin
            status = ST_MALFORMED;
        end else begin
            status = (received == i_xor) ? ST_VALID : ST_MISMATCH;
        end

        plen_full = PlW'(i_len) - PlW'(DIGIT_COUNT);

        o_res.status   = status;
        o_res.computed = i_xor;
        o_res.received = received;
        if (status != ST_VALID) begin
            o_res.plen = 8'd0;
        end else if (plen_full > PlW'(255)) begin
            o_res.plen = 8'hFF;
        end else begin
            o_res.plen = plen_full[7:0];
        end
    end

endmodule

// ===== rtl/nmea_sentence_checksum_checker.sv =====
// Top level of the NMEA 0183 sentence checksum checker.
// Depends on nmea_chk_pkg, the three channel interfaces and nmea_chk_eval.

// Takes one sentence byte per transaction on i_in, with last_byte set on the
// final byte, and returns one result transaction on o_out for each sentence:
// status (valid, checksum mismatch, malformed/too short, length out of range),
// the XOR of the payload, the decoded trailing hex checksum and the payload
// length (sentence length minus two). A leading '$' is not part of the XOR,
// the byte three from the end must be '*'. The block accepts one byte every
// clock cycle: each byte updates a running XOR and a three-byte delay line,
// and the final byte's result lands in the output register on the edge that
// accepts it, so it is offered on o_out in the cycle after. Input ready only
// drops while that output register holds a result the sink has not yet
// taken. skip_check is written through i_cfg (always ready) and should only
// change between sentences. Sentences longer than MAX_SENTENCE_LEN bytes
// report status "length out of range" regardless of skip_check.
module nmea_sentence_checksum_checker
    import nmea_chk_pkg::*;
#(
    parameter int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nmea_chk_in_if.sink     i_in,
    nmea_chk_out_if.source  o_out,
    nmea_chk_cfg_if.sink    i_cfg
);

    localparam int CntW = $clog2(MAX_SENTENCE_LEN + 2);

    // Per-sentence state
    logic [CntW-1:0] r_cnt,    n_cnt;     // saturates at MAX_SENTENCE_LEN+1
    logic [7:0]      r_xor,    n_xor;
    logic [2:0][7:0] r_tail,   n_tail;    // newest byte at index 0
    logic            r_dollar, n_dollar;
    logic            r_skip;

    // Output register
    logic            r_out_valid;
    t_result         r_res;
    t_result         res;

    logic            in_fire;
    logic            is_dollar;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    // Next sentence state for the byte on the input
    always_comb begin
        is_dollar = (r_cnt == '0) && (i_in.data_byte == DOLLAR_CHAR);
        n_dollar  = r_dollar;
        n_xor     = r_xor;
        n_tail    = r_tail;
        if (is_dollar) begin
            n_dollar = 1'b1;
        end else begin
            // Oldest tail byte leaves the delay line into the XOR once it is
            // known not to be part of the "*hh" trailer.
            if ((r_cnt - CntW'(r_dollar)) >= CntW'(3)) begin
                n_xor = r_xor ^ r_tail[2];
            end
            n_tail = {r_tail[1], r_tail[0], i_in.data_byte};
        end
        n_cnt = (r_cnt <= CntW'(MAX_SENTENCE_LEN)) ? r_cnt + CntW'(1) : r_cnt;
    end

    nmea_chk_eval #(
        .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
    ) u_eval (
        .i_len    (n_cnt),
        .i_dollar (n_dollar),
        .i_tail   (n_tail),
        .i_xor    (n_xor),
        .i_skip   (r_skip),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_xor       <= '0;
            r_tail      <= '0;
            r_dollar    <= 1'b0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_skip <= i_cfg.skip_check;
            end
            if (in_fire) begin
                if (i_in.last_byte) begin
                    // Sentence done: clear for the next one
                    r_cnt    <= '0;
                    r_xor    <= '0;
                    r_tail   <= '0;
                    r_dollar <= 1'b0;
                end else begin
                    r_cnt    <= n_cnt;
                    r_xor    <= n_xor;
                    r_tail   <= n_tail;
                    r_dollar <= n_dollar;
                end
            end
            if (in_fire && i_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.last_byte) begin
            r_res <= res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_res.status;
    assign o_out.computed_checksum = r_res.computed;
    assign o_out.received_checksum = r_res.received;
    assign o_out.payload_length    = r_res.plen;

endmodule

// ===== rtl/nmea_chk_checker.sv =====
// Port-level assertions for the checksum checker, bound to its top level.
// Depends on nmea_chk_pkg and nmea_sentence_checksum_checker_defines.svh.
`include "nmea_sentence_checksum_checker_defines.svh"

module nmea_chk_checker
    import nmea_chk_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_status    i_status,
    input logic [7:0] i_computed,
    input logic [7:0] i_received,
    input logic [7:0] i_plen
);

    // Length is reported only for good sentences
    `NMEA_CHK_ASSERT(a_plen_zero, i_out_valid && (i_status != ST_VALID), i_plen == 8'd0, "payload length set on a failed sentence")

    // A mismatch must really disagree
    `NMEA_CHK_ASSERT(a_mismatch, i_out_valid && (i_status == ST_MISMATCH), i_received != i_computed, "mismatch reported on equal checksums")

    // A new result only follows a final byte
    `NMEA_CHK_ASSERT(a_res_src, i_out_valid && !$past(i_out_valid), $past(i_in_valid && i_in_ready && i_in_last), "result without a final byte")

    // Stalled result holds
    `NMEA_CHK_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_computed), "stalled result changed")

endmodule

bind nmea_sentence_checksum_checker nmea_chk_checker u_nmea_chk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_computed  (o_out.computed_checksum),
    .i_received  (o_out.received_checksum),
    .i_plen      (o_out.payload_length)
);
